FILE: hdl/spg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spg_pkg: shared types and constants
// Request codes, register indexes and sequencer states of the stepper pulse
// generator.
// ----------------------------------------------------------------------------
package spg_pkg;

    // request opcodes
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_MOVE_STEPS = 2'd1;
    localparam logic [1:0] OP_MOVE_ANGLE = 2'd2;
    localparam logic [1:0] OP_SET_POWER  = 2'd3;

    // direction codes for step moves
    localparam logic [1:0] DIR_CW  = 2'd0;
    localparam logic [1:0] DIR_CCW = 2'd1;

    // configuration register indexes
    localparam logic CFG_MIN_HALF = 1'b0;
    localparam logic CFG_STEPS    = 1'b1;

    // register reset values
    localparam logic [15:0] MIN_HALF_RST = 16'd10;
    localparam logic [8:0]  STEPS_RST    = 9'd200;

    // degrees in a full turn
    localparam logic [15:0] DEG_FULL = 16'd360;

    // shared divider: 16-bit dividend, 9-bit divisor, one quotient bit a cycle
    localparam int unsigned DIV_BITS = 16;
    localparam int unsigned DEN_BITS = 9;
    localparam int unsigned DIV_CNT_BITS = $clog2(DIV_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_PER,
        ST_DIV_MAG
    } t_state;

endpackage : spg_pkg
`default_nettype wire

FILE: hdl/stepper_pulse_generator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_pulse_generator_unit: step/direction pulse generator
// Plays out step pulse trains for a stepper driver from tick, move and power
// requests; angle moves go through a shared iterative divider.
// ----------------------------------------------------------------------------
// Each request yields exactly one result, shown on the step, direction and
// enable pin levels plus busy and rejected flags. Tick, step-move and power
// requests, and rejected moves, complete in the accept cycle and the result
// is valid on the next cycle. An angle move goes through one shared
// restoring divider, one quotient bit per cycle, which first forms the angle
// per step (360 / steps_setting) and then the step count
// (|target - last target| / angle per step); the result is registered when
// the second division ends. The input is stalled while the divider runs and
// while an earlier result is held by a stalled consumer. A move that arrives
// while pulses remain is dropped and flagged as rejected; power requests
// always act. Configuration writes are meant for idle periods only.
module stepper_pulse_generator_unit
    import spg_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [1:0]  i_direction,
    input  wire logic [15:0] i_amount,
    input  wire logic [15:0] i_half_period,
    input  wire logic        i_power_on,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_step_pulse,
    output logic             o_dir_level,
    output logic             o_enable_pin_level,
    output logic             o_busy_res,
    output logic             o_rejected
);

    localparam int unsigned CW = COUNT_WIDTH;
    // saturation limit of the pulse and tick counters
    localparam logic [63:0] CNT_MAX64 = (64'd1 << COUNT_WIDTH) - 64'd1;

    // saturate a 16-bit count into the counter width
    function automatic logic [CW-1:0] f_sat(input logic [15:0] v);
        logic [63:0] w;
        begin
            w = 64'(v);
            if (w > CNT_MAX64) begin
                w = CNT_MAX64;
            end
            return w[CW-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [15:0] r_min_half;
    logic [8:0]  r_steps_set;

    logic r_pulse, n_pulse;
    logic r_dir, n_dir;
    logic r_en, n_en;
    logic r_rej, n_rej;
    logic r_out_valid, n_out_valid;

    logic [CW-1:0] r_steps_left, n_steps_left;
    logic [CW-1:0] r_half_left, n_half_left;
    logic [CW-1:0] r_act_half, n_act_half;
    logic [15:0]   r_last_target, n_last_target;

    // angle request latch (payload, no reset)
    logic [15:0] r_target, n_target;
    logic [15:0] r_req_half, n_req_half;

    // shared divider (payload, no reset)
    logic [DEN_BITS-1:0]     r_div_rem, n_div_rem;
    logic [DIV_BITS-1:0]     r_div_quo, n_div_quo;
    logic [DEN_BITS-1:0]     r_div_den, n_div_den;
    logic [DIV_CNT_BITS-1:0] r_div_cnt, n_div_cnt;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic in_acc;
    logic busy;

    assign busy       = (r_steps_left != '0);
    assign o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // divider step: shift in the next dividend bit, subtract if it fits
    // ------------------------------------------------------------------
    logic [DEN_BITS:0]   div_shift;
    logic                div_ge;
    logic [DEN_BITS:0]   div_diff;
    logic [DEN_BITS-1:0] step_rem;
    logic [DIV_BITS-1:0] step_quo;

    always_comb begin
        div_shift = {r_div_rem, r_div_quo[DIV_BITS-1]};
        div_ge    = (div_shift >= {1'b0, r_div_den});
        div_diff  = div_shift - {1'b0, r_div_den};
        step_rem  = div_ge ? div_diff[DEN_BITS-1:0] : div_shift[DEN_BITS-1:0];
        step_quo  = {r_div_quo[DIV_BITS-2:0], div_ge};
    end

    // angle per step; zero (no setting, or setting above a full turn) counts as 1
    logic [DEN_BITS-1:0] per_val;
    assign per_val = ((r_steps_set == '0) || (step_quo == '0)) ?
                     DEN_BITS'(1) : step_quo[DEN_BITS-1:0];

    // distance to the latched target
    logic        tgt_up;
    logic        tgt_down;
    logic [15:0] tgt_mag;
    assign tgt_up   = (r_target > r_last_target);
    assign tgt_down = (r_target < r_last_target);
    assign tgt_mag  = tgt_up ? (r_target - r_last_target) : (r_last_target - r_target);

    // clamped half period for a move; the requested half comes from the
    // port on a step move and from the latch on an angle move
    logic [15:0]   arm_req;
    logic [15:0]   arm_h16;
    logic [CW-1:0] arm_half;

    assign arm_req = (r_state == ST_IDLE) ? i_half_period : r_req_half;

    always_comb begin
        arm_h16 = (arm_req <= r_min_half) ? r_min_half : arm_req;
        if (arm_h16 == '0) begin
            arm_h16 = 16'd1;
        end
        arm_half = f_sat(arm_h16);
    end

    // pulse count for the move being armed
    logic [CW-1:0] arm_cnt;
    assign arm_cnt = (r_state == ST_IDLE) ? f_sat(i_amount) : f_sat(step_quo);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_opcode == OP_MOVE_ANGLE) && !busy) begin
                    n_state = ST_DIV_PER;
                end
            end
            ST_DIV_PER: begin
                if (r_div_cnt == '0) begin
                    n_state = ST_DIV_MAG;
                end
            end
            ST_DIV_MAG: begin
                if (r_div_cnt == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_pulse       = r_pulse;
        n_dir         = r_dir;
        n_en          = r_en;
        n_rej         = r_rej;
        n_out_valid   = r_out_valid && i_out_stall;
        n_steps_left  = r_steps_left;
        n_half_left   = r_half_left;
        n_act_half    = r_act_half;
        n_last_target = r_last_target;
        n_target      = r_target;
        n_req_half    = r_req_half;
        n_div_rem     = r_div_rem;
        n_div_quo     = r_div_quo;
        n_div_den     = r_div_den;
        n_div_cnt     = r_div_cnt;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_rej       = 1'b0;
                    n_out_valid = 1'b1;
                    if (i_opcode == OP_TICK) begin
                        if (busy) begin
                            if (r_half_left > CW'(1)) begin
                                n_half_left = r_half_left - CW'(1);
                            end else if (r_pulse) begin
                                n_pulse     = 1'b0;
                                n_half_left = r_act_half;
                            end else begin
                                n_steps_left = r_steps_left - CW'(1);
                                if (r_steps_left != CW'(1)) begin
                                    n_pulse     = 1'b1;
                                    n_half_left = r_act_half;
                                end else begin
                                    n_half_left = '0;
                                end
                            end
                        end
                    end else if (i_opcode == OP_SET_POWER) begin
                        n_en = !i_power_on;
                    end else if (busy) begin
                        n_rej = 1'b1;
                    end else if (i_opcode == OP_MOVE_STEPS) begin
                        if (i_direction == DIR_CW) begin
                            n_dir = 1'b1;
                        end else if (i_direction == DIR_CCW) begin
                            n_dir = 1'b0;
                        end
                        n_en         = 1'b0;
                        n_act_half   = arm_half;
                        n_steps_left = arm_cnt;
                        n_pulse      = (arm_cnt != '0);
                        n_half_left  = (arm_cnt != '0) ? arm_half : '0;
                    end else begin
                        // angle move: start 360 / steps_setting
                        n_out_valid = 1'b0;
                        n_target    = i_amount;
                        n_req_half  = i_half_period;
                        n_div_rem   = '0;
                        n_div_quo   = DIV_BITS'(DEG_FULL);
                        n_div_den   = r_steps_set;
                        n_div_cnt   = DIV_CNT_BITS'(DIV_BITS - 1);
                    end
                end
            end
            ST_DIV_PER: begin
                n_div_rem = step_rem;
                n_div_quo = step_quo;
                n_div_cnt = r_div_cnt - DIV_CNT_BITS'(1);
                if (r_div_cnt == '0) begin
                    // start |delta| / angle per step
                    n_div_rem = '0;
                    n_div_quo = tgt_mag;
                    n_div_den = per_val;
                    n_div_cnt = DIV_CNT_BITS'(DIV_BITS - 1);
                end
            end
            ST_DIV_MAG: begin
                n_div_rem = step_rem;
                n_div_quo = step_quo;
                n_div_cnt = r_div_cnt - DIV_CNT_BITS'(1);
                if (r_div_cnt == '0) begin
                    if (tgt_up) begin
                        n_dir = 1'b1;
                    end else if (tgt_down) begin
                        n_dir = 1'b0;
                    end
                    n_en          = 1'b0;
                    n_act_half    = arm_half;
                    n_steps_left  = arm_cnt;
                    n_pulse       = (arm_cnt != '0);
                    n_half_left   = (arm_cnt != '0) ? arm_half : '0;
                    n_last_target = r_target;
                    n_rej         = 1'b0;
                    n_out_valid   = 1'b1;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_min_half    <= MIN_HALF_RST;
            r_steps_set   <= STEPS_RST;
            r_pulse       <= 1'b0;
            r_dir         <= 1'b0;
            r_en          <= 1'b1;
            r_rej         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_steps_left  <= '0;
            r_half_left   <= '0;
            r_act_half    <= '0;
            r_last_target <= '0;
        end else begin
            r_state       <= n_state;
            r_pulse       <= n_pulse;
            r_dir         <= n_dir;
            r_en          <= n_en;
            r_rej         <= n_rej;
            r_out_valid   <= n_out_valid;
            r_steps_left  <= n_steps_left;
            r_half_left   <= n_half_left;
            r_act_half    <= n_act_half;
            r_last_target <= n_last_target;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_HALF: r_min_half  <= i_cfg_data;
                    CFG_STEPS:    r_steps_set <= i_cfg_data[8:0];
                    default:      r_min_half  <= r_min_half;
                endcase
            end
        end
    end

    // divider and request latch
    always_ff @(posedge i_clk) begin
        r_target   <= n_target;
        r_req_half <= n_req_half;
        r_div_rem  <= n_div_rem;
        r_div_quo  <= n_div_quo;
        r_div_den  <= n_div_den;
        r_div_cnt  <= n_div_cnt;
    end

    // pins reflect state, which only moves when a request is accepted or completes
    assign o_out_valid        = r_out_valid;
    assign o_step_pulse       = r_pulse;
    assign o_dir_level        = r_dir;
    assign o_enable_pin_level = r_en;
    assign o_busy_res         = busy;
    assign o_rejected         = r_rej;

endmodule : stepper_pulse_generator_unit
`default_nettype wire

FILE: hdl/spg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spg_checker: port-level checks
// Watches the ports of the stepper pulse generator over time.
// ----------------------------------------------------------------------------
module spg_checker
    import spg_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [1:0] i_opcode,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_step_pulse,
    input wire logic       o_enable_pin_level,
    input wire logic       o_busy_res,
    input wire logic       o_rejected
);

    // held result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a dropped move leaves the running train in place
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_busy_res)
        else $error("reject flagged while idle");

    // no train, no pulse
    a_idle_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy_res |-> !o_step_pulse)
        else $error("step pin high while idle");

    // an accepted step move enables the driver on the next result
    a_move_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_opcode == OP_MOVE_STEPS) && !o_busy_res
        |=> o_out_valid && !o_enable_pin_level)
        else $error("step move did not enable driver");

    // an accepted angle move waits for the divider
    a_angle_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_opcode == OP_MOVE_ANGLE) && !o_busy_res
        |=> !o_out_valid && o_in_stall)
        else $error("angle move result too early");

endmodule : spg_checker

bind stepper_pulse_generator_unit spg_checker u_spg_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .i_opcode           (i_opcode),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_step_pulse       (o_step_pulse),
    .o_enable_pin_level (o_enable_pin_level),
    .o_busy_res         (o_busy_res),
    .o_rejected         (o_rejected)
);
`default_nettype wire

FILE: dv/stepper_pulse_generator_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_pulse_generator_unit_tb: self-checking bench for the pulse generator
// Sends tick, move and power requests with random gaps and random output
// stalls, predicts every result from a cycle-free model of the pin logic, and
// compares each result field by field, in order.
// ----------------------------------------------------------------------------
module stepper_pulse_generator_unit_tb;
    import spg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles without any handshake before the run is declared hung
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // receiver hold-off used to back the block up
    localparam int unsigned LONG_HOLD = 80;
    // cap on ticks needed to play out one random train
    localparam longint TRAIN_TICK_CAP = 400;

    typedef struct packed {
        logic step_pulse;
        logic dir_level;
        logic enable_pin_level;
        logic busy_res;
        logic rejected;
    } t_pin_state;

    // DUT ports; the inputs are all known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = CFG_MIN_HALF;
    logic [15:0] i_cfg_data    = '0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_opcode      = OP_TICK;
    logic [1:0]  i_direction   = DIR_CW;
    logic [15:0] i_amount      = '0;
    logic [15:0] i_half_period = '0;
    logic        i_power_on    = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic        o_step_pulse;
    logic        o_dir_level;
    logic        o_enable_pin_level;
    logic        o_busy_res;
    logic        o_rejected;

    // ---- predicted pin logic state and register copies ----
    logic        pulse_q         = 1'b0;
    logic        dir_q           = 1'b0;
    logic        enable_q        = 1'b1;   // active low, disabled out of reset
    logic [15:0] pulses_left     = '0;     // includes the pulse in progress
    logic [15:0] half_ticks_left = '0;
    logic [15:0] train_half      = '0;
    logic [15:0] prev_angle      = '0;
    logic [15:0] cfg_min_half    = MIN_HALF_RST;
    logic [8:0]  cfg_steps       = STEPS_RST;

    // expected pin states, oldest first
    t_pin_state  expected_pins[$];

    // ---- bench knobs and counters ----
    bit          in_idle_en      = 1'b1;
    bit          out_idle_en     = 1'b1;
    int unsigned out_hold_cycles = 0;
    int unsigned sent_count      = 0;
    int unsigned result_count    = 0;
    int unsigned err_count       = 0;
    int unsigned idle_cycles     = 0;

    string pin_names[5] = '{"step_pulse", "dir_level", "enable_pin_level",
                            "busy_res", "rejected"};

    stepper_pulse_generator_unit #(
        .COUNT_WIDTH(16)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_direction       (i_direction),
        .i_amount          (i_amount),
        .i_half_period     (i_half_period),
        .i_power_on        (i_power_on),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_step_pulse      (o_step_pulse),
        .o_dir_level       (o_dir_level),
        .o_enable_pin_level(o_enable_pin_level),
        .o_busy_res        (o_busy_res),
        .o_rejected        (o_rejected)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Pin logic prediction
    // ------------------------------------------------------------------------

    // requested half period raised to the configured floor, never zero
    function automatic logic [15:0] clamp_half(input logic [15:0] req);
        logic [15:0] h;
        h = (req <= cfg_min_half) ? cfg_min_half : req;
        if (h == 0) h = 16'd1;
        return h;
    endfunction

    // degrees per step; a zero quotient (setting 0 or above a full turn) is 1
    function automatic logic [15:0] angle_per_step();
        logic [15:0] per;
        per = (cfg_steps != 0) ? DEG_FULL / cfg_steps : 16'd0;
        if (per == 0) per = 16'd1;
        return per;
    endfunction

    function automatic void arm_train(input logic [15:0] count, input logic [15:0] req);
        logic [15:0] h;
        h = clamp_half(req);
        enable_q    = 1'b0;
        train_half  = h;
        pulses_left = count;
        if (count != 0) begin
            pulse_q         = 1'b1;
            half_ticks_left = h;
        end else begin
            pulse_q         = 1'b0;
            half_ticks_left = '0;
        end
    endfunction

    // one microsecond tick: count down the half, flip the pin, retire a step
    function automatic void advance_tick();
        if (pulses_left == 0) return;
        if (half_ticks_left > 1) begin
            half_ticks_left--;
        end else if (pulse_q) begin
            pulse_q         = 1'b0;
            half_ticks_left = train_half;
        end else begin
            pulses_left--;
            if (pulses_left != 0) begin
                pulse_q         = 1'b1;
                half_ticks_left = train_half;
            end else begin
                half_ticks_left = '0;
            end
        end
    endfunction

    function automatic t_pin_state predict_pins(input logic [1:0] op, input logic [1:0] dir,
                                                input logic [15:0] amt,
                                                input logic [15:0] half, input logic pwr);
        t_pin_state  pins;
        logic [15:0] mag;
        logic        was_busy;
        was_busy     = (pulses_left != 0);
        pins.rejected = 1'b0;
        case (op)
            OP_TICK: begin
                advance_tick();
            end
            OP_SET_POWER: begin
                enable_q = ~pwr;
            end
            default: begin
                if (was_busy) begin
                    // a move during a train is dropped without side effects
                    pins.rejected = 1'b1;
                end else if (op == OP_MOVE_STEPS) begin
                    if (dir == DIR_CW) dir_q = 1'b1;
                    else if (dir == DIR_CCW) dir_q = 1'b0;
                    arm_train(amt, half);
                end else begin
                    if (amt > prev_angle) begin
                        dir_q = 1'b1;
                        mag   = amt - prev_angle;
                    end else if (amt < prev_angle) begin
                        dir_q = 1'b0;
                        mag   = prev_angle - amt;
                    end else begin
                        mag = '0;
                    end
                    arm_train(mag / angle_per_step(), half);
                    prev_angle = amt;   // taken even when no step results
                end
            end
        endcase
        pins.step_pulse       = pulse_q;
        pins.dir_level        = dir_q;
        pins.enable_pin_level = enable_q;
        pins.busy_res         = (pulses_left != 0);
        return pins;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    task automatic report_error(input string msg);
        $display("ERROR [%0t] %s", $realtime, msg);
        err_count++;
    endtask

    // Offer one request and hold it until accepted. Valid stays high on return
    // so a back-to-back request keeps the channel busy without a bubble.
    task automatic send_request(input logic [1:0] op, input logic [1:0] dir,
                                input logic [15:0] amt, input logic [15:0] half,
                                input logic pwr);
        int unsigned gap;
        gap = in_idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_direction   <= dir;
        i_amount      <= amt;
        i_half_period <= half;
        i_power_on    <= pwr;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        expected_pins.push_back(predict_pins(op, dir, amt, half, pwr));
        sent_count++;
    endtask

    task automatic send_tick();
        send_request(OP_TICK, 2'($urandom_range(0, 3)), 16'($urandom),
                     16'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_power(input logic pwr);
        send_request(OP_SET_POWER, 2'($urandom_range(0, 3)), 16'($urandom),
                     16'($urandom), pwr);
    endtask

    // a move with random content, sent while a train runs
    task automatic send_stray_move();
        send_request(2'($urandom_range(1, 2)), 2'($urandom_range(0, 3)), 16'($urandom),
                     16'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // tick until the predicted train has played out
    task automatic drain_train();
        while (pulses_left != 0) send_tick();
    endtask

    // park the request channel until every result is back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_pins.size() != 0);
    endtask

    // registers only change with the block idle
    task automatic set_config(input logic [15:0] min_half, input logic [8:0] steps);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MIN_HALF;
        i_cfg_data  <= min_half;
        @(posedge i_clk);
        i_cfg_index <= CFG_STEPS;
        i_cfg_data  <= {7'd0, steps};
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        cfg_min_half = min_half;
        cfg_steps    = steps;
    endtask

    // target angle that yields the wanted step count from the last target
    function automatic logic [15:0] pick_angle(input int unsigned steps_wanted);
        int per;
        int delta;
        int tgt;
        per   = int'(angle_per_step());
        delta = int'(steps_wanted) * per + int'($urandom_range(0, per - 1));
        if ($urandom_range(0, 1)) delta = -delta;
        tgt = int'(prev_angle) + delta;
        if (tgt < 0 || tgt > 65535) tgt = int'(prev_angle) - delta;
        return 16'(tgt);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, optional long hold, in-order compare
    // ------------------------------------------------------------------------
    initial begin : result_checker
        int unsigned n;
        t_pin_state  got;
        t_pin_state  want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (out_hold_cycles > 0) begin
                n               = out_hold_cycles;
                out_hold_cycles = 0;
            end else begin
                n = out_idle_en ? $urandom_range(0, 4) : 0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            got = {o_step_pulse, o_dir_level, o_enable_pin_level, o_busy_res, o_rejected};
            result_count++;
            if (expected_pins.size() == 0) begin
                report_error($sformatf("result %0d arrived with no request pending",
                                       result_count));
            end else begin
                want = expected_pins.pop_front();
                for (int b = 0; b < 5; b++) begin
                    if (got[4-b] !== want[4-b])
                        report_error($sformatf("result %0d %s: got %b, expected %b",
                                               result_count, pin_names[b],
                                               got[4-b], want[4-b]));
                end
            end
        end
    end

    // hang detector: any handshake on either channel clears the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR [%0t] no handshake for %0d cycles", $realtime, idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset state shows on an idle tick; power acts on the enable pin only
    task automatic test_reset_and_power();
        send_tick();
        send_power(1'b1);
        send_power(1'b0);
        send_power(1'b1);
    endtask

    // direction codes, zero count, zero half period, clamp to the floor
    task automatic test_step_moves();
        send_request(OP_MOVE_STEPS, 2'd2, 16'd0, 16'd0, 1'b0);
        send_request(OP_MOVE_STEPS, DIR_CW, 16'd0, 16'hFFFF, 1'b1);
        send_request(OP_MOVE_STEPS, 2'd3, 16'd0, 16'd5, 1'b0);
        send_request(OP_MOVE_STEPS, DIR_CCW, 16'd0, 16'd0, 1'b1);
        set_config(16'd0, 9'd360);
        send_request(OP_MOVE_STEPS, DIR_CW, 16'd1, 16'd0, 1'b0);
        drain_train();
        set_config(16'd3, 9'd360);
        send_request(OP_MOVE_STEPS, 2'd2, 16'd1, 16'd2, 1'b0);
        drain_train();
    endtask

    // sign of the delta, zero delta, degenerate step settings, sub-step delta
    task automatic test_angle_moves();
        set_config(16'd0, 9'd0);
        send_request(OP_MOVE_ANGLE, 2'd0, 16'd0, 16'd0, 1'b0);
        send_request(OP_MOVE_ANGLE, 2'd1, 16'd1, 16'd0, 1'b0);
        drain_train();
        send_request(OP_MOVE_ANGLE, 2'd3, 16'd0, 16'd0, 1'b1);
        drain_train();
        set_config(16'd0, 9'd400);
        send_request(OP_MOVE_ANGLE, 2'd0, 16'd1, 16'd0, 1'b0);
        drain_train();
        set_config(16'd0, 9'd1);
        send_request(OP_MOVE_ANGLE, 2'd0, 16'd359, 16'd0, 1'b0);
        send_request(OP_MOVE_ANGLE, 2'd0, 16'd0, 16'd0, 1'b0);
        send_request(OP_MOVE_ANGLE, 2'd0, 16'd719, 16'd0, 1'b0);
        drain_train();
    endtask

    // moves during a train are flagged and dropped; power still acts
    task automatic test_busy_rejects();
        send_request(OP_MOVE_STEPS, DIR_CW, 16'd1, 16'd1, 1'b0);
        send_request(OP_MOVE_ANGLE, 2'd3, 16'hFFFF, 16'hFFFF, 1'b1);
        send_request(OP_MOVE_STEPS, 2'd3, 16'hFFFF, 16'hFFFF, 1'b1);
        send_power(1'b0);
        send_power(1'b1);
        drain_train();
    endtask

    // One well-formed train: a move, then ticks until it has played out, with
    // the odd power request or stray move mixed in.
    task automatic run_train();
        logic [15:0] half;
        logic [15:0] tgt;
        int unsigned cnt;
        int unsigned r;
        longint      diff;
        in_idle_en  = ($urandom_range(0, 3) != 0);
        out_idle_en = ($urandom_range(0, 3) != 0);
        r    = $urandom_range(0, 9);
        cnt  = $urandom_range(0, 6);
        // large half periods only with a zero count; only a full-range jump under the tick cap can then arm pulses
        half = (cnt == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        if (r < 4) begin
            send_request(OP_MOVE_STEPS, 2'($urandom_range(0, 3)), 16'(cnt), half,
                         1'($urandom_range(0, 1)));
        end else begin
            tgt = pick_angle(cnt);
            if (r == 9) begin
                // full-range jump, kept only if it plays out in reasonable time
                tgt  = 16'($urandom);
                diff = longint'(tgt) - longint'(prev_angle);
                if (diff < 0) diff = -diff;
                if ((diff / angle_per_step()) * 2 * clamp_half(half) > TRAIN_TICK_CAP)
                    tgt = pick_angle(cnt);
            end
            send_request(OP_MOVE_ANGLE, 2'($urandom_range(0, 3)), tgt, half,
                         1'($urandom_range(0, 1)));
        end
        while (pulses_left != 0) begin
            r = $urandom_range(0, 19);
            if (r == 0) send_stray_move();
            else if (r == 1) send_power(1'($urandom_range(0, 1)));
            else send_tick();
        end
        repeat ($urandom_range(0, 2)) send_tick();
    endtask

    task automatic run_random_phase(input logic [15:0] min_half, input logic [8:0] steps,
                                    input int unsigned n_items);
        int unsigned start;
        set_config(min_half, steps);
        start = sent_count;
        while (sent_count - start < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                run_train();
            end else if ($urandom_range(0, 1)) begin
                send_tick();
            end else begin
                send_power(1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_random_trains();
        run_random_phase(16'd0, 9'd360, 265);
        run_random_phase(16'd1, 9'd1,   265);
        run_random_phase(16'd2, 9'd200, 265);
        run_random_phase(16'd3, 9'd0,   265);
        run_random_phase(16'd0, 9'd511, 265);
        run_random_phase(16'd1, 9'd45,  265);
    endtask

    // receiver holds off while requests keep coming, so the input backs up
    task automatic test_backpressure();
        set_config(16'd1, 9'd90);
        in_idle_en      = 1'b0;
        out_idle_en     = 1'b0;
        out_hold_cycles = LONG_HOLD;
        send_request(OP_MOVE_STEPS, DIR_CW, 16'd4, 16'd1, 1'b0);
        repeat (30) begin
            if ($urandom_range(0, 4) == 0) send_power(1'($urandom_range(0, 1)));
            else send_tick();
        end
        drain_train();
        wait_results_drained();
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
    endtask

    // top of the range: floor and count at full scale; the train is left running
    task automatic test_long_train();
        set_config(16'hFFFF, 9'd360);
        send_request(OP_MOVE_STEPS, DIR_CW, 16'hFFFF, 16'd0, 1'b0);
        repeat (20) send_tick();
        send_stray_move();
        send_power(1'b0);
        repeat (5) send_tick();
        send_power(1'b1);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_and_power();
        test_step_moves();
        test_angle_moves();
        test_busy_rejects();
        test_random_trains();
        test_backpressure();
        test_long_train();
        wait_results_drained();
        // leave room for a stray result
        repeat (40) @(posedge i_clk);
        if (expected_pins.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_pins.size()));
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule : stepper_pulse_generator_unit_tb
`default_nettype wire
